FILE: src/shp_pkg.sv
// Shared types and constants of the SIP header pre-parser.
package shp_pkg;

    localparam int OFFSET_BITS = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_START = 3'd1;
    localparam logic [2:0] EV_VALUE = 3'd2;
    localparam logic [2:0] EV_EMPTY = 3'd3;
    localparam logic [2:0] EV_DONE  = 3'd4;
    localparam logic [2:0] EV_ERROR = 3'd5;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] name_start;
        logic [15:0] name_len;
        logic [15:0] span_start;
        logic [15:0] span_len;
        logic        flatten;
        logic        known_header;
        logic        last;
    } res_t;

    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } qent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: src/shp_in_if.sv
// Byte input channel of the SIP header pre-parser.
interface shp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       name_known;
    logic       name_is_list;

    modport source (output valid, data_byte, name_known, name_is_list, input ready);
    modport sink (input valid, data_byte, name_known, name_is_list, output ready);
endinterface

FILE: src/shp_out_if.sv
// Result output channel of the SIP header pre-parser.
interface shp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [15:0] name_start;
    logic [15:0] name_len;
    logic [15:0] span_start;
    logic [15:0] span_len;
    logic        flatten;
    logic        known_header;
    logic        last;

    modport source (output valid, event_res, name_start, name_len, span_start, span_len,
                     flatten, known_header, last, input ready);
    modport sink (input valid, event_res, name_start, name_len, span_start, span_len,
                   flatten, known_header, last, output ready);
endinterface

FILE: src/sip_header_preparser.sv
// Top level of the SIP header pre-parser: front part, record queue and back part.
//
// The block reads a SIP message one byte per item and reports its structure: the start
// line, each header name and value span as byte offsets from the start of the message,
// empty headers, line ends inside a value that read as a space, the end of the headers
// and errors. The header-name classifier flags are sampled with the colon byte. A byte
// is accepted in every cycle while the four-entry record queue has room; the whole
// transition for a byte, including the second pass of a back edge or of an error
// restart, is evaluated in the cycle it is accepted. Each byte gives one result, or two
// when it ends a header on a back edge or raises an error; results leave the output
// register one per cycle while the output is ready, and a result passes through the
// record queue and then the output register. A stalled output fills the queue and then
// holds off input. After the empty line that ends the headers, the next byte starts a
// new message at offset zero. Offsets wrap at 2^16.
module sip_header_preparser (
    input  logic      clk,
    input  logic      rst_n,
    shp_in_if.sink    bytes_in,
    shp_out_if.source results_out
);

    shp_pkg::q_stat_t q_stat;
    shp_pkg::qent_t   push_entry;
    shp_pkg::qent_t   head;
    logic             push;
    logic             pop;

    shp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (bytes_in),
        .stat       (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    shp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    shp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .stat    (q_stat),
        .pop     (pop),
        .res_out (results_out)
    );

    // An error result is always followed by the restart pass of the same byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results_out.valid && results_out.event_res == shp_pkg::EV_ERROR)
        |-> !results_out.last)
    else $error("error result marked as last");

    // The second result of a byte follows right after the first one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results_out.valid && results_out.ready && !results_out.last)
        |=> results_out.valid)
    else $error("second result of a byte did not follow");

    // With nothing in flight, an accepted byte shows a result by way of the record queue and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_in.valid && bytes_in.ready && q_stat.empty && !results_out.valid)
        |-> ##2 results_out.valid)
    else $error("result of an idle-time byte did not appear");

    // A full queue that is not popped does not lose its records.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && !pop) |=> !q_stat.empty)
    else $error("queue lost its records");

endmodule

FILE: src/shp_front.sv
// Front part: accepts bytes, runs the parse state machine and builds result records.
module shp_front (
    input  logic             clk,
    input  logic             rst_n,
    shp_in_if.sink           byte_in,
    input  shp_pkg::q_stat_t stat,
    output logic             push,
    output shp_pkg::qent_t   push_entry
);

    localparam int OB = shp_pkg::OFFSET_BITS;
    localparam logic [OB-1:0] ONE_OFF = {{(OB-1){1'b0}}, 1'b1};

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_QUOT  = 8'd34;
    localparam logic [7:0] CH_LANG  = 8'd60;
    localparam logic [7:0] CH_RANG  = 8'd62;
    localparam logic [7:0] CH_BSL   = 8'd92;

    localparam logic [9:0] W_NONE  = 10'h000;
    localparam logic [9:0] W_ADD   = 10'h001;
    localparam logic [9:0] W_HDR   = 10'h002;
    localparam logic [9:0] W_RESET = 10'h004;
    localparam logic [9:0] W_FLAT  = 10'h008;
    localparam logic [9:0] W_BACK  = 10'h010;
    localparam logic [9:0] W_BAD   = 10'h020;
    localparam logic [9:0] W_FLINE = 10'h040;
    localparam logic [9:0] W_DATA  = 10'h080;
    localparam logic [9:0] W_EMPTY = 10'h100;
    localparam logic [9:0] W_ENDH  = 10'h200;

    typedef enum logic [4:0] {
        ST_NEWMSG, ST_NEWMSG_CRLF, ST_START, ST_START_CRLF, ST_BUILD_HDR,
        ST_WS_POST_HDR, ST_WS_POST_COLON, ST_EMPTY_CRLF, ST_EMPTY_CONT,
        ST_BUILD_DATA, ST_DATA_CRLF, ST_CHECK_CONT, ST_CHECK_END, ST_IN_ANG,
        ST_IN_ANG_Q, ST_IN_ANG_Q_ESC, ST_IN_Q, ST_IN_Q_ESC, ST_END_MSG
    } pstate_t;

    typedef struct packed {
        pstate_t       st;
        logic          list_mode;
        logic          latched_known;
        logic [OB-1:0] bp;
        logic [OB-1:0] ab;
        logic [OB-1:0] ae;
        logic [OB-1:0] ho;
        logic [OB-1:0] hl;
    } pctx_t;

    typedef struct packed {
        pstate_t    nxt;
        logic [9:0] w;
    } edge_t;

    typedef struct packed {
        pctx_t          ctx;
        shp_pkg::res_t  res;
        logic [9:0]     w;
    } pres_t;

    localparam pctx_t CTX_RESTART = '{st: ST_NEWMSG, list_mode: 1'b0, latched_known: 1'b0,
                                      bp: '0, ab: '0, ae: '0, ho: '0, hl: '0};

    function automatic edge_t mk(input pstate_t n, input logic [9:0] w);
        edge_t e;
        e.nxt = n;
        e.w   = w;
        return e;
    endfunction

    // Transition table: next state and work flags for one byte.
    function automatic edge_t edge_f(input pstate_t st, input logic [7:0] c, input logic lst);
        edge_t e;
        logic  lws;
        lws = (c == CH_SP) || (c == CH_TAB);
        e   = mk(ST_END_MSG, W_BAD);
        unique case (st)
            ST_NEWMSG:
                if (c == CH_CR) e = mk(ST_NEWMSG_CRLF, W_NONE);
                else            e = mk(ST_START, W_ADD);
            ST_NEWMSG_CRLF:
                if (c == CH_LF) e = mk(ST_NEWMSG, W_NONE);
            ST_START:
                if (c == CH_CR) e = mk(ST_START_CRLF, W_NONE);
                else            e = mk(ST_START, W_ADD);
            ST_START_CRLF:
                if (c == CH_LF) e = mk(ST_BUILD_HDR, W_RESET | W_FLINE);
            ST_BUILD_HDR:
                priority if (lws)           e = mk(ST_WS_POST_HDR, W_NONE);
                else if (c == CH_COLON)     e = mk(ST_WS_POST_COLON, W_HDR | W_RESET);
                else                        e = mk(ST_BUILD_HDR, W_ADD);
            ST_WS_POST_HDR:
                priority if (lws)           e = mk(ST_WS_POST_HDR, W_NONE);
                else if (c == CH_COLON)     e = mk(ST_WS_POST_COLON, W_HDR | W_RESET);
                else                        e = mk(ST_END_MSG, W_BAD);
            ST_WS_POST_COLON:
                priority if (lws)             e = mk(ST_WS_POST_COLON, W_RESET);
                else if (c == CH_CR)          e = mk(ST_EMPTY_CRLF, W_RESET);
                else if (lst && c == CH_LANG) e = mk(ST_IN_ANG, W_ADD);
                else if (lst && c == CH_QUOT) e = mk(ST_IN_Q, W_ADD);
                else                          e = mk(ST_BUILD_DATA, W_ADD);
            ST_EMPTY_CRLF:
                if (c == CH_LF) e = mk(ST_EMPTY_CONT, W_RESET);
            ST_EMPTY_CONT:
                priority if (lws)    e = mk(ST_WS_POST_COLON, W_RESET);
                else if (c == CH_CR) e = mk(ST_CHECK_END, W_RESET | W_EMPTY);
                else                 e = mk(ST_BUILD_HDR, W_RESET | W_BACK | W_EMPTY);
            ST_BUILD_DATA:
                priority if (c == CH_CR)       e = mk(ST_DATA_CRLF, W_FLAT);
                else if (lst && c == CH_LANG)  e = mk(ST_IN_ANG, W_ADD);
                else if (lst && c == CH_QUOT)  e = mk(ST_IN_Q, W_ADD);
                else if (lst && c == CH_COMMA) e = mk(ST_WS_POST_COLON, W_DATA | W_RESET);
                else                           e = mk(ST_BUILD_DATA, W_ADD);
            ST_DATA_CRLF:
                if (c == CH_LF) e = mk(ST_CHECK_CONT, W_FLAT);
            ST_CHECK_CONT:
                priority if (lws)    e = mk(ST_BUILD_DATA, W_ADD);
                else if (c == CH_CR) e = mk(ST_CHECK_END, W_DATA | W_RESET);
                else                 e = mk(ST_BUILD_HDR, W_DATA | W_RESET | W_BACK);
            ST_CHECK_END:
                if (c == CH_LF) e = mk(ST_END_MSG, W_ENDH);
            ST_IN_ANG:
                priority if (c == CH_RANG) e = mk(ST_BUILD_DATA, W_ADD);
                else if (c == CH_QUOT)     e = mk(ST_IN_ANG_Q, W_ADD);
                else                       e = mk(ST_IN_ANG, W_ADD);
            ST_IN_ANG_Q:
                priority if (c == CH_QUOT) e = mk(ST_IN_ANG, W_ADD);
                else if (c == CH_BSL)      e = mk(ST_IN_ANG_Q_ESC, W_ADD);
                else                       e = mk(ST_IN_ANG_Q, W_ADD);
            ST_IN_ANG_Q_ESC:
                e = mk(ST_IN_ANG_Q, W_ADD);
            ST_IN_Q:
                priority if (c == CH_QUOT) e = mk(ST_BUILD_DATA, W_ADD);
                else if (c == CH_BSL)      e = mk(ST_IN_Q_ESC, W_ADD);
                else                       e = mk(ST_IN_Q, W_ADD);
            ST_IN_Q_ESC:
                e = mk(ST_IN_Q, W_ADD);
            default:
                e = mk(ST_NEWMSG, W_NONE);
        endcase
        return e;
    endfunction

    // One pass of the machine over a byte: new context and one result.
    function automatic pres_t pass_f(input pctx_t s, input logic [7:0] c,
                                     input logic known, input logic islist);
        edge_t         e;
        pctx_t         n;
        logic [OB-1:0] ss;
        logic [OB-1:0] sl;
        logic [2:0]    ev;
        pres_t         r;
        n  = s;
        e  = edge_f(s.st, c, s.list_mode);
        ss = '0;
        sl = '0;
        ev = shp_pkg::EV_NONE;
        if ((e.w & W_ADD) != W_NONE) n.ae = n.bp;
        if ((e.w & W_HDR) != W_NONE) begin
            n.ho            = n.ab;
            n.hl            = n.ae - n.ab + ONE_OFF;
            n.latched_known = known;
            n.list_mode     = islist;
        end
        if ((e.w & W_EMPTY) != W_NONE) ev = shp_pkg::EV_EMPTY;
        if ((e.w & (W_DATA | W_FLINE)) != W_NONE) begin
            ev = ((e.w & W_DATA) != W_NONE) ? shp_pkg::EV_VALUE : shp_pkg::EV_START;
            ss = n.ab;
            sl = n.ae - n.ab + ONE_OFF;
        end
        if ((e.w & W_ENDH) != W_NONE) ev = shp_pkg::EV_DONE;
        if ((e.w & W_BAD) != W_NONE)  ev = shp_pkg::EV_ERROR;
        if ((e.w & (W_BACK | W_BAD)) == W_NONE) n.bp = n.bp + ONE_OFF;
        n.st = e.nxt;
        if ((e.w & W_RESET) != W_NONE) begin
            n.ab = n.bp;
            n.ae = n.bp;
        end
        r.ctx                  = n;
        r.w                    = e.w;
        r.res.event_res        = ev;
        r.res.name_start       = 16'(n.ho);
        r.res.name_len         = 16'(n.hl);
        r.res.span_start       = 16'(ss);
        r.res.span_len         = 16'(sl);
        r.res.flatten          = ((e.w & W_FLAT) != W_NONE);
        r.res.known_header     = n.latched_known;
        r.res.last             = 1'b0;
        return r;
    endfunction

    pctx_t ctx_reg;
    pctx_t ctx_next;
    pctx_t ctx_start;
    pctx_t ctx_mid;
    pres_t p1;
    pres_t p2;
    logic  two;

    assign byte_in.ready = !stat.full;
    assign push          = byte_in.valid && byte_in.ready;

    always_comb
    begin
        ctx_start = (ctx_reg.st >= ST_END_MSG) ? CTX_RESTART : ctx_reg;
        p1 = pass_f(ctx_start, byte_in.data_byte, byte_in.name_known, byte_in.name_is_list);
        // An error restarts the message; a back edge keeps the context.
        ctx_mid = ((p1.w & W_BAD) != W_NONE) ? CTX_RESTART : p1.ctx;
        p2 = pass_f(ctx_mid, byte_in.data_byte, byte_in.name_known, byte_in.name_is_list);
        two = ((p1.w & (W_BAD | W_BACK)) != W_NONE);

        push_entry.r0      = p1.res;
        push_entry.r0.last = !two;
        push_entry.r1      = p2.res;
        push_entry.r1.last = 1'b1;
        push_entry.two     = two;

        ctx_next = ctx_reg;
        if (push) ctx_next = two ? p2.ctx : p1.ctx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ctx_reg <= CTX_RESTART;
        else        ctx_reg <= ctx_next;
    end

endmodule

FILE: src/shp_queue.sv
// Short queue of result records between the front and back parts.
module shp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  shp_pkg::qent_t    push_entry,
    input  logic              pop,
    output shp_pkg::qent_t    head,
    output shp_pkg::q_stat_t  stat
);

    localparam int AW = shp_pkg::QUEUE_AW;
    localparam int CW = shp_pkg::QUEUE_CW;
    localparam logic [AW-1:0] LAST_PTR  = AW'(shp_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(shp_pkg::QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);
    localparam logic [AW-1:0] ONE_PTR   = AW'(1);

    shp_pkg::qent_t entry_reg [shp_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + ONE_PTR;
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + ONE_PTR;
        if (do_push && !do_pop)      count_next = count_reg + ONE_CNT;
        else if (do_pop && !do_push) count_next = count_reg - ONE_CNT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

FILE: src/shp_back.sv
// Back part: sends the one or two results of each record through the output register.
module shp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  shp_pkg::qent_t   head,
    input  shp_pkg::q_stat_t stat,
    output logic             pop,
    shp_out_if.source        res_out
);

    logic          out_valid_reg;
    logic          out_valid_next;
    shp_pkg::res_t out_data_reg;
    shp_pkg::res_t out_data_next;
    logic          sub_reg;
    logic          sub_next;
    logic          load;

    assign load = !stat.empty && (!out_valid_reg || res_out.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sub_next       = sub_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sub_reg ? head.r1 : head.r0;
            pop            = sub_reg || !head.two;
            sub_next       = !pop;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.event_res    = out_data_reg.event_res;
    assign res_out.name_start   = out_data_reg.name_start;
    assign res_out.name_len     = out_data_reg.name_len;
    assign res_out.span_start   = out_data_reg.span_start;
    assign res_out.span_len     = out_data_reg.span_len;
    assign res_out.flatten      = out_data_reg.flatten;
    assign res_out.known_header = out_data_reg.known_header;
    assign res_out.last         = out_data_reg.last;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the SIP header pre-parser: directed and random messages.
module testbench;

    // Run control. The limit covers the slowest correct run several times over:
    // about 1900 items with full gaps and two fully stalled results each.
    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int DRAIN_CYCLES   = 16;
    localparam int GAP_MAX        = 19;

    // Bytes that steer the parser.
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_QUOT  = 8'd34;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_LANG  = 8'd60;
    localparam logic [7:0] CH_RANG  = 8'd62;
    localparam logic [7:0] CH_BSL   = 8'd92;

    // States of the byte-driven parser.
    typedef enum logic [4:0] {
        ST_NEWMSG, ST_NEWMSG_CRLF, ST_START, ST_START_CRLF, ST_BUILD_HDR, ST_WS_POST_HDR,
        ST_WS_POST_COLON, ST_EMPTY_CRLF, ST_EMPTY_CONT, ST_BUILD_DATA, ST_DATA_CRLF,
        ST_CHECK_CONT, ST_CHECK_END, ST_IN_ANG, ST_IN_ANG_Q, ST_IN_ANG_Q_ESC, ST_IN_Q,
        ST_IN_Q_ESC, ST_END_MSG
    } parse_state_t;

    // Actions that a transition requests.
    localparam logic [9:0] WB_NONE  = 10'd0;
    localparam logic [9:0] WB_ADD   = 10'd1;
    localparam logic [9:0] WB_HDR   = 10'd2;
    localparam logic [9:0] WB_RESET = 10'd4;
    localparam logic [9:0] WB_FLAT  = 10'd8;
    localparam logic [9:0] WB_BACK  = 10'd16;
    localparam logic [9:0] WB_BAD   = 10'd32;
    localparam logic [9:0] WB_FLINE = 10'd64;
    localparam logic [9:0] WB_DATA  = 10'd128;
    localparam logic [9:0] WB_EMPTY = 10'd256;
    localparam logic [9:0] WB_ENDH  = 10'd512;

    // Tracks the parser state, predicts the results of every accepted byte and
    // checks the results that leave the block against them in order.
    class sip_parse_scoreboard;
        parse_state_t   pstate;
        logic           list_mode;
        logic           known_latch;
        logic [15:0]    position;
        logic [15:0]    anchor_lo;
        logic [15:0]    anchor_hi;
        logic [15:0]    name_offset;
        logic [15:0]    name_length;
        shp_pkg::res_t  expected_results[$];
        int unsigned    failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            pstate      = ST_NEWMSG;
            list_mode   = 1'b0;
            known_latch = 1'b0;
            position    = '0;
            anchor_lo   = '0;
            anchor_hi   = '0;
            name_offset = '0;
            name_length = '0;
        endfunction

        // Returns {next state, action bits}; any byte that no branch takes is an error.
        function logic [14:0] transition(logic [7:0] c);
            logic        lws;
            logic [14:0] t;
            lws = (c == CH_SP) || (c == CH_TAB);
            t   = {ST_END_MSG, WB_BAD};
            case (pstate)
                ST_NEWMSG:
                    t = (c == CH_CR) ? {ST_NEWMSG_CRLF, WB_NONE} : {ST_START, WB_ADD};
                ST_NEWMSG_CRLF:
                    if (c == CH_LF)
                        t = {ST_NEWMSG, WB_NONE};
                ST_START:
                    t = (c == CH_CR) ? {ST_START_CRLF, WB_NONE} : {ST_START, WB_ADD};
                ST_START_CRLF:
                    if (c == CH_LF)
                        t = {ST_BUILD_HDR, WB_RESET | WB_FLINE};
                ST_BUILD_HDR:
                    if (lws)
                        t = {ST_WS_POST_HDR, WB_NONE};
                    else if (c == CH_COLON)
                        t = {ST_WS_POST_COLON, WB_HDR | WB_RESET};
                    else
                        t = {ST_BUILD_HDR, WB_ADD};
                ST_WS_POST_HDR:
                    if (lws)
                        t = {ST_WS_POST_HDR, WB_NONE};
                    else if (c == CH_COLON)
                        t = {ST_WS_POST_COLON, WB_HDR | WB_RESET};
                ST_WS_POST_COLON:
                    if (lws)
                        t = {ST_WS_POST_COLON, WB_RESET};
                    else if (c == CH_CR)
                        t = {ST_EMPTY_CRLF, WB_RESET};
                    else if (list_mode && c == CH_LANG)
                        t = {ST_IN_ANG, WB_ADD};
                    else if (list_mode && c == CH_QUOT)
                        t = {ST_IN_Q, WB_ADD};
                    else
                        t = {ST_BUILD_DATA, WB_ADD};
                ST_EMPTY_CRLF:
                    if (c == CH_LF)
                        t = {ST_EMPTY_CONT, WB_RESET};
                ST_EMPTY_CONT:
                    if (lws)
                        t = {ST_WS_POST_COLON, WB_RESET};
                    else if (c == CH_CR)
                        t = {ST_CHECK_END, WB_RESET | WB_EMPTY};
                    else
                        t = {ST_BUILD_HDR, WB_RESET | WB_BACK | WB_EMPTY};
                ST_BUILD_DATA:
                    if (c == CH_CR)
                        t = {ST_DATA_CRLF, WB_FLAT};
                    else if (list_mode && c == CH_LANG)
                        t = {ST_IN_ANG, WB_ADD};
                    else if (list_mode && c == CH_QUOT)
                        t = {ST_IN_Q, WB_ADD};
                    else if (list_mode && c == CH_COMMA)
                        t = {ST_WS_POST_COLON, WB_DATA | WB_RESET};
                    else
                        t = {ST_BUILD_DATA, WB_ADD};
                ST_DATA_CRLF:
                    if (c == CH_LF)
                        t = {ST_CHECK_CONT, WB_FLAT};
                ST_CHECK_CONT:
                    if (lws)
                        t = {ST_BUILD_DATA, WB_ADD};
                    else if (c == CH_CR)
                        t = {ST_CHECK_END, WB_DATA | WB_RESET};
                    else
                        t = {ST_BUILD_HDR, WB_DATA | WB_RESET | WB_BACK};
                ST_CHECK_END:
                    if (c == CH_LF)
                        t = {ST_END_MSG, WB_ENDH};
                ST_IN_ANG:
                    if (c == CH_RANG)
                        t = {ST_BUILD_DATA, WB_ADD};
                    else if (c == CH_QUOT)
                        t = {ST_IN_ANG_Q, WB_ADD};
                    else
                        t = {ST_IN_ANG, WB_ADD};
                ST_IN_ANG_Q:
                    if (c == CH_QUOT)
                        t = {ST_IN_ANG, WB_ADD};
                    else if (c == CH_BSL)
                        t = {ST_IN_ANG_Q_ESC, WB_ADD};
                    else
                        t = {ST_IN_ANG_Q, WB_ADD};
                ST_IN_ANG_Q_ESC:
                    t = {ST_IN_ANG_Q, WB_ADD};
                ST_IN_Q:
                    if (c == CH_QUOT)
                        t = {ST_BUILD_DATA, WB_ADD};
                    else if (c == CH_BSL)
                        t = {ST_IN_Q_ESC, WB_ADD};
                    else
                        t = {ST_IN_Q, WB_ADD};
                ST_IN_Q_ESC:
                    t = {ST_IN_Q, WB_ADD};
                default:
                    t = {ST_NEWMSG, WB_NONE};
            endcase
            return t;
        endfunction

        // One pass of the parser over a byte; updates the state and forms one result.
        function logic [9:0] parse_pass(logic [7:0] c, logic known, logic islist,
                                        output shp_pkg::res_t r);
            logic [14:0]  t;
            logic [9:0]   w;
            parse_state_t nxt;
            logic [2:0]   ev;
            logic [15:0]  ss;
            logic [15:0]  sl;
            t   = transition(c);
            nxt = parse_state_t'(t[14:10]);
            w   = t[9:0];
            ev  = shp_pkg::EV_NONE;
            ss  = '0;
            sl  = '0;
            if ((w & WB_ADD) != 0)
                anchor_hi = position;
            if ((w & WB_HDR) != 0)
            begin
                name_offset = anchor_lo;
                name_length = anchor_hi - anchor_lo + 16'd1;
                known_latch = known;
                list_mode   = islist;
            end
            if ((w & WB_EMPTY) != 0)
                ev = shp_pkg::EV_EMPTY;
            if ((w & (WB_DATA | WB_FLINE)) != 0)
            begin
                ev = ((w & WB_DATA) != 0) ? shp_pkg::EV_VALUE : shp_pkg::EV_START;
                ss = anchor_lo;
                sl = anchor_hi - anchor_lo + 16'd1;
            end
            if ((w & WB_ENDH) != 0)
                ev = shp_pkg::EV_DONE;
            if ((w & WB_BAD) != 0)
                ev = shp_pkg::EV_ERROR;
            // A re-read byte does not advance the offset.
            if ((w & (WB_BACK | WB_BAD)) == 0)
                position = position + 16'd1;
            pstate = nxt;
            if ((w & WB_RESET) != 0)
            begin
                anchor_lo = position;
                anchor_hi = position;
            end
            r.event_res    = ev;
            r.name_start   = name_offset;
            r.name_len     = name_length;
            r.span_start   = ss;
            r.span_len     = sl;
            r.flatten      = ((w & WB_FLAT) != 0);
            r.known_header = known_latch;
            r.last         = 1'b0;
            return w;
        endfunction

        function void note_byte(logic [7:0] c, logic known, logic islist);
            shp_pkg::res_t first;
            shp_pkg::res_t second;
            logic [9:0]    w;
            if (pstate == ST_END_MSG)
                restart();
            w = parse_pass(c, known, islist, first);
            if ((w & (WB_BAD | WB_BACK)) != 0)
            begin
                // An error restarts the message before the byte is read again.
                if ((w & WB_BAD) != 0)
                    restart();
                void'(parse_pass(c, known, islist, second));
                second.last = 1'b1;
                expected_results.push_back(first);
                expected_results.push_back(second);
            end
            else
            begin
                first.last = 1'b1;
                expected_results.push_back(first);
            end
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(shp_pkg::res_t act);
            shp_pkg::res_t want;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item: event_res %0d", act.event_res);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("event_res", want.event_res, act.event_res);
            compare_field("name_start", want.name_start, act.name_start);
            compare_field("name_len", want.name_len, act.name_len);
            compare_field("span_start", want.span_start, act.span_start);
            compare_field("span_len", want.span_len, act.span_len);
            compare_field("flatten", want.flatten, act.flatten);
            compare_field("known_header", want.known_header, act.known_header);
            compare_field("last", want.last, act.last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    shp_in_if  byte_ch();
    shp_out_if result_ch();

    sip_header_preparser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes_in    (byte_ch),
        .results_out (result_ch)
    );

    sip_parse_scoreboard sb;

    // Current upper bound of the per-item wait on each side; zero gives a
    // stretch with no idling at all.
    int unsigned src_gap_max = GAP_MAX;
    int unsigned dst_gap_max = GAP_MAX;
    int unsigned cycle_count = 0;

    // Bytes of the message being sent.
    logic [7:0] msg[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a run that stalls or runs away ends as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("** sip_header_preparser: FAILED **");
            $finish;
        end
    end

    function automatic int unsigned draw_gap(int unsigned max_gap);
        return (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    endfunction

    // Plain printable byte that opens no quoted or bracketed run and splits nothing.
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (c inside {CH_COLON, CH_QUOT, CH_LANG, CH_RANG, CH_COMMA, CH_BSL});
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        return ($urandom_range(0, 1) == 0) ? CH_SP : CH_TAB;
    endfunction

    // Noise leans on the bytes that steer the parser, with any byte now and then.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 14))
            0: return CH_CR;
            1: return CH_LF;
            2: return CH_SP;
            3: return CH_TAB;
            4: return CH_COLON;
            5: return CH_COMMA;
            6: return CH_QUOT;
            7: return CH_LANG;
            8: return CH_RANG;
            9: return CH_BSL;
            10: return text_char();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Body of a quoted string with backslash escapes; an escaped byte may be anything.
    function automatic void append_quoted_body();
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                msg.push_back(CH_BSL);
                msg.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                          : text_char());
            end
            else
                msg.push_back(text_char());
        end
    endfunction

    // One piece of a header value: text, a list comma, a quoted string or an
    // angle-bracketed run that may hold a quoted string.
    function automatic void append_value_segment();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 6)) msg.push_back(text_char());
            1:
            begin
                msg.push_back(CH_COMMA);
                if ($urandom_range(0, 1) == 0)
                    msg.push_back(CH_SP);
            end
            2:
            begin
                msg.push_back(CH_QUOT);
                append_quoted_body();
                msg.push_back(CH_QUOT);
            end
            default:
            begin
                msg.push_back(CH_LANG);
                repeat ($urandom_range(0, 4)) msg.push_back(text_char());
                if ($urandom_range(0, 1) == 0)
                begin
                    msg.push_back(CH_QUOT);
                    append_quoted_body();
                    msg.push_back(CH_QUOT);
                end
                msg.push_back(CH_RANG);
            end
        endcase
    endfunction

    // Offers one byte item after a random wait and returns at the edge that accepts it.
    // When no wait is drawn, valid stays high and only the payload changes.
    task automatic send_byte(logic [7:0] c, logic known, logic islist);
        int unsigned gap;
        gap = draw_gap(src_gap_max);
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= c;
        byte_ch.name_known   <= known;
        byte_ch.name_is_list <= islist;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        sb.note_byte(c, known, islist);
    endtask

    // The classifier flags only matter on a colon; they are random on every byte.
    task automatic send_message();
        foreach (msg[i])
            send_byte(msg[i], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Holds the sender off until every expected result has left the block.
    // At least one clock passes, so valid is never lowered and raised in one step.
    task automatic wait_for_results();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_results.size() != 0);
    endtask

    // Result side: ready drops for a random number of cycles before each item.
    // Every accepted result is checked against the oldest prediction.
    initial
    begin : result_sink
        shp_pkg::res_t got;
        int unsigned   stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 79) == 0)
                dst_gap_max = (dst_gap_max == 0) ? GAP_MAX : 0;
            stall = draw_gap(dst_gap_max);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
            got.event_res    = result_ch.event_res;
            got.name_start   = result_ch.name_start;
            got.name_len     = result_ch.name_len;
            got.span_start   = result_ch.span_start;
            got.span_len     = result_ch.span_len;
            got.flatten      = result_ch.flatten;
            got.known_header = result_ch.known_header;
            got.last         = result_ch.last;
            sb.check_result(got);
        end
    end

    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned cut;
        int unsigned n_lines;
        sb = new();
        rst_n                <= 1'b0;
        byte_ch.valid        <= 1'b0;
        byte_ch.data_byte    <= '0;
        byte_ch.name_known   <= 1'b0;
        byte_ch.name_is_list <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed message. It walks a blank line before the start line, a list
        // header with an angle run holding a quoted string with an escaped 0xFF
        // byte, a comma split, an empty value that ends on a back edge, white
        // space before a colon, a folded value, the end of the headers, a restart
        // on a zero byte and an error after CR that restarts on the same byte.
        // The classifier flags are high for the first colon and low for the second.
        msg = '{CH_CR, CH_LF, "I", CH_CR, CH_LF, "a", CH_COLON, CH_LANG, CH_QUOT, CH_BSL,
                8'hFF, CH_QUOT, CH_RANG, CH_COMMA, CH_CR, CH_LF, "b", CH_SP, CH_COLON, "v",
                CH_CR, CH_LF, CH_TAB, "w", CH_CR, CH_LF, CH_CR, CH_LF, 8'h00, CH_CR, "x"};
        foreach (msg[i])
            send_byte(msg[i], (i < 12), (i < 12));
        wait_for_results();

        // Random part: mostly well-formed messages with random content, some of
        // them damaged or cut short, and bursts of noise between them.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            msg.delete();
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 12)) msg.push_back(noise_byte());
            else
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    msg.push_back(CH_CR);
                    msg.push_back(CH_LF);
                end
                repeat ($urandom_range(1, 12))
                    msg.push_back(($urandom_range(0, 5) == 0) ? CH_SP : text_char());
                msg.push_back(CH_CR);
                msg.push_back(CH_LF);
                repeat ($urandom_range(0, 5))
                begin
                    repeat ($urandom_range(1, 8)) msg.push_back(text_char());
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 2)) msg.push_back(blank_char());
                    msg.push_back(CH_COLON);
                    repeat ($urandom_range(0, 2)) msg.push_back(blank_char());
                    // Some values, empty ones too, are folded over further lines.
                    n_lines = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : 1;
                    for (int ln = 0; ln < n_lines; ln++)
                    begin
                        if (ln != 0)
                        begin
                            msg.push_back(CH_CR);
                            msg.push_back(CH_LF);
                            msg.push_back(blank_char());
                        end
                        repeat ($urandom_range(0, 3)) append_value_segment();
                    end
                    msg.push_back(CH_CR);
                    msg.push_back(CH_LF);
                end
                msg.push_back(CH_CR);
                msg.push_back(CH_LF);
                // Now and then a message is damaged at one byte or cut short.
                if ($urandom_range(0, 5) == 0)
                begin
                    cut = $urandom_range(0, msg.size() - 1);
                    if ($urandom_range(0, 1) == 0)
                        msg[cut] = noise_byte();
                    else
                        while (msg.size() > cut + 1)
                            void'(msg.pop_back());
                end
            end
            send_message();
            random_sent += msg.size();
            if ($urandom_range(0, 24) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("** sip_header_preparser: PASSED **");
        else
            $display("** sip_header_preparser: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
src/shp_pkg.sv
src/shp_in_if.sv
src/shp_out_if.sv
src/shp_front.sv
src/shp_queue.sv
src/shp_back.sv
src/sip_header_preparser.sv
verif/testbench.sv
